FILE: rtl/kpm_pkg.sv
package kpm_pkg;

  // table geometry and count width
  localparam int MaxPatterns = 256;
  localparam int MaxPatternLen = 16;
  localparam int CountWidth = 16;

  typedef enum logic [1:0] {
    CMD_LOAD_BYTE = 2'd0,
    CMD_SET_HEADER = 2'd1,
    CMD_TEXT_BYTE = 2'd2,
    CMD_END_TEXT = 2'd3
  } kpm_cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_READ,
    ST_CMP,
    ST_DONE,
    ST_OUT
  } kpm_state_e;

  // controller to datapath
  typedef struct packed {
    logic shift;     // shift the text history
    logic wr_byte;   // write pattern byte
    logic wr_hdr;    // write pattern header
    logic clr;       // clear block count at sweep address
    logic clr_hdr;   // also clear header at sweep address
    logic rd;        // read entry at sweep address
    logic cmp;       // compare one pattern byte
    logic upd;       // finish entry update
    logic clr_tot;   // clear totals and history
    logic cnt_rst;   // reset sweep counter
    logic cnt_inc;   // next entry
    logic pos_rst;   // reset byte position
    logic pos_inc;   // next byte position
    logic load_out;  // capture result
  } kpm_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic last_entry;
    logic skip;       // entry needs no byte compare
    logic cmp_done;   // compare loop finished
  } kpm_stat_t;

endpackage

FILE: rtl/kpm_ctrl.sv
module kpm_ctrl
  import kpm_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  logic [1:0] cmd_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  kpm_stat_t stat_i,
  output kpm_cmd_t  ctl_o
);

  kpm_state_e state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic clear_q, clear_d;  // header clear pending after reset

  always_comb begin
    state_d = state_q;
    clear_d = clear_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    case (state_q)
      ST_CLEAR: if (stat_i.last_entry) begin
        state_d = ST_IDLE;
        clear_d = 1'b0;
      end
      ST_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          case (kpm_cmd_e'(cmd_i))
            CMD_TEXT_BYTE: state_d = ST_READ;
            CMD_END_TEXT: state_d = ST_OUT;
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_READ: state_d = ST_CMP;
      ST_CMP: if (stat_i.skip || stat_i.cmp_done) state_d = ST_DONE;
      ST_DONE: state_d = stat_i.last_entry ? ST_IDLE : ST_READ;
      ST_OUT: if (!out_valid_q || out_ready_i) begin
        out_valid_d = 1'b1;
        state_d = ST_CLEAR;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl_o = '0;
    in_ready_o = (state_q == ST_IDLE);
    case (state_q)
      ST_IDLE: begin
        ctl_o.cnt_rst = 1'b1;
        if (in_valid_i) begin
          ctl_o.wr_byte = (kpm_cmd_e'(cmd_i) == CMD_LOAD_BYTE);
          ctl_o.wr_hdr = (kpm_cmd_e'(cmd_i) == CMD_SET_HEADER);
          ctl_o.shift = (kpm_cmd_e'(cmd_i) == CMD_TEXT_BYTE);
        end
      end
      ST_CLEAR: begin
        ctl_o.clr = 1'b1;
        ctl_o.clr_hdr = clear_q;
        ctl_o.cnt_inc = 1'b1;
      end
      ST_READ: begin
        ctl_o.rd = 1'b1;
        ctl_o.pos_rst = 1'b1;
      end
      ST_CMP: begin
        if (!stat_i.skip && !stat_i.cmp_done) begin
          ctl_o.cmp = 1'b1;
          ctl_o.pos_inc = 1'b1;
        end
      end
      ST_DONE: begin
        ctl_o.upd = 1'b1;
        ctl_o.cnt_inc = 1'b1;
      end
      ST_OUT: begin
        ctl_o.cnt_rst = 1'b1;
        if (!out_valid_q || out_ready_i) begin
          ctl_o.load_out = 1'b1;
          ctl_o.clr_tot = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clear_q <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clear_q <= clear_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

FILE: rtl/kpm_datapath.sv
module kpm_datapath
  import kpm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  kpm_cmd_t    ctl_i,
  input  logic [7:0]  pattern_index_i,
  input  logic [3:0]  char_pos_i,
  input  logic [7:0]  data_byte_i,
  input  logic [4:0]  pattern_length_i,
  input  logic        polarity_i,
  output kpm_stat_t   stat_o,
  output logic signed [1:0] sentiment_o,
  output logic [15:0] positive_count_o,
  output logic [15:0] negative_count_o
);

  localparam int IW = (MaxPatterns > 1) ? $clog2(MaxPatterns) : 1;
  localparam int PW = $clog2(MaxPatternLen);
  localparam int LW = $clog2(MaxPatternLen + 1);
  localparam int HD = MaxPatternLen + 1;
  localparam int HW = $clog2(HD + 1);
  localparam int EW = IW + PW;
  localparam logic [CountWidth-1:0] CountMax = '1;

  logic [7:0] byte_mem [MaxPatterns*MaxPatternLen];
  logic [LW:0] meta_mem [MaxPatterns];  // {pol, len}
  logic [PW-1:0] blk_mem [MaxPatterns];

  logic [7:0] hist_q [HD];
  logic [HW-1:0] seen_q;
  logic [CountWidth-1:0] pos_q, neg_q;
  logic [IW:0] ent_q;
  logic [PW:0] cpos_q;
  logic mis_q;
  logic [7:0] rbyte_q;
  logic [7:0] hb_d;
  logic signed [1:0] sent_q;
  logic [15:0] pout_q, nout_q;
  logic [LW:0] meta_rd_q;
  logic [PW-1:0] blk_rd_q;

  logic [IW-1:0] ent;
  logic [LW-1:0] hlen;
  logic idx_ok, pos_ok;
  logic [7:0] lc;

  // fields of the entry under sweep, from the registered reads
  logic [LW-1:0] ent_len;
  logic [PW-1:0] ent_blk;
  logic ent_pol;
  assign {ent_pol, ent_len} = meta_rd_q;
  assign ent_blk = blk_rd_q;

  assign ent = ent_q[IW-1:0];
  assign idx_ok = ({24'd0, pattern_index_i} < 32'(MaxPatterns));
  assign pos_ok = ({28'd0, char_pos_i} < 32'(MaxPatternLen));
  assign hlen = ({27'd0, pattern_length_i} > 32'(MaxPatternLen)) ?
                LW'(MaxPatternLen) : LW'(pattern_length_i);
  assign lc = (data_byte_i >= 8'h41 && data_byte_i <= 8'h5a) ?
              data_byte_i + 8'h20 : data_byte_i;

  logic skip;
  logic [HW-1:0] hidx;
  logic [7:0] hb;
  logic [7:0] before_b;
  assign skip = (ent_len == '0) || (ent_blk != '0) || ({{(32-HW){1'b0}}, seen_q} <
                {{(32-LW){1'b0}}, ent_len});
  assign stat_o.skip = skip;
  assign stat_o.cmp_done = mis_q || ({{(31-PW){1'b0}}, cpos_q} ==
                {{(32-LW){1'b0}}, ent_len} + 32'd1);
  assign stat_o.last_entry = (ent_q == (IW+1)'(MaxPatterns - 1));
  assign hidx = HW'(ent_len) - HW'(cpos_q) - HW'(1);
  assign hb = hist_q[hidx[$clog2(HD)-1:0]];
  assign before_b = hist_q[ent_len];

  // pattern byte read, registered
  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_byte && idx_ok && pos_ok)
      byte_mem[{pattern_index_i[IW-1:0], char_pos_i[PW-1:0]}] <= data_byte_i;
    rbyte_q <= byte_mem[EW'({ent, cpos_q[PW-1:0]})];
  end

  logic [PW-1:0] nblk;
  logic hit, count;
  assign hit = !skip && !mis_q;
  assign count = hit && (seen_q == HW'(ent_len) ||
                 !(before_b >= 8'h61 && before_b <= 8'h7a));
  always_comb begin
    nblk = ent_blk;
    if (ent_len != '0) begin
      if (ent_blk != '0) nblk = ent_blk - 1'b1;
      else if (hit) nblk = PW'(ent_len - 1'b1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_hdr && idx_ok)
      meta_mem[pattern_index_i[IW-1:0]] <= {polarity_i, hlen};
    else if (ctl_i.clr_hdr)
      meta_mem[ent] <= '0;
    meta_rd_q <= meta_mem[ent];
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_hdr && idx_ok)
      blk_mem[pattern_index_i[IW-1:0]] <= '0;
    else if (ctl_i.clr)
      blk_mem[ent] <= '0;
    else if (ctl_i.upd)
      blk_mem[ent] <= nblk;
    blk_rd_q <= blk_mem[ent];
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.rd) mis_q <= 1'b0;
    else if (ctl_i.cmp && cpos_q != '0 && rbyte_q != hb_d) mis_q <= 1'b1;
    if (ctl_i.load_out) begin
      sent_q <= (pos_q > neg_q) ? 2'sd1 : (neg_q > pos_q) ? -2'sd1 : 2'sd0;
      pout_q <= 16'(pos_q);
      nout_q <= 16'(neg_q);
    end
  end

  // history byte lined up with the registered pattern byte
  always_ff @(posedge clk_i) hb_d <= hb;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < HD; k++) hist_q[k] <= '0;
      seen_q <= '0;
      pos_q <= '0;
      neg_q <= '0;
      ent_q <= '0;
      cpos_q <= '0;
    end else begin
      if (ctl_i.clr_tot) begin
        for (int k = 0; k < HD; k++) hist_q[k] <= '0;
        seen_q <= '0;
        pos_q <= '0;
        neg_q <= '0;
      end else if (ctl_i.shift) begin
        for (int k = HD - 1; k > 0; k--) hist_q[k] <= hist_q[k-1];
        hist_q[0] <= lc;
        if (seen_q < HW'(HD)) seen_q <= seen_q + 1'b1;
      end else if (ctl_i.upd && count) begin
        if (ent_pol) neg_q <= (neg_q == CountMax) ? neg_q : neg_q + 1'b1;
        else pos_q <= (pos_q == CountMax) ? pos_q : pos_q + 1'b1;
      end
      if (ctl_i.cnt_rst) ent_q <= '0;
      else if (ctl_i.cnt_inc) ent_q <= ent_q + 1'b1;
      if (ctl_i.pos_rst) cpos_q <= '0;
      else if (ctl_i.pos_inc) cpos_q <= cpos_q + 1'b1;
    end
  end

  assign sentiment_o = sent_q;
  assign positive_count_o = pout_q;
  assign negative_count_o = nout_q;

endmodule

FILE: rtl/keyword_polarity_matcher_core.sv
// Keyword polarity matcher: a table of up to MaxPatterns keywords (each up to
// MaxPatternLen bytes, tagged positive or negative) is matched against a
// lowercased text stream. Table loads and header writes are taken in the idle
// state. Each accepted text byte then sweeps every table entry in turn: an
// entry that is unused, blocked or longer than the text so far goes through
// read, check and block count update; any other entry adds a byte-at-a-time
// compare before the update, cut short when a byte mismatches. End of text
// loads the result once the output register is free, then runs a clearing
// pass over the block counts of every entry; a pass that also clears the
// headers follows reset. No transfer is accepted during a sweep or a pass.
module keyword_polarity_matcher_core
  import kpm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  cmd_i,
  input  logic [7:0]  pattern_index_i,
  input  logic [3:0]  char_pos_i,
  input  logic [7:0]  data_byte_i,
  input  logic [4:0]  pattern_length_i,
  input  logic        polarity_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic signed [1:0] sentiment_o,
  output logic [15:0] positive_count_o,
  output logic [15:0] negative_count_o
);

  kpm_cmd_t  ctl;
  kpm_stat_t stat;

  // sequencer for commands, entry sweep and result transfer
  kpm_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .cmd_i,
    .out_valid_o, .out_ready_i, .stat_i(stat), .ctl_o(ctl)
  );

  // pattern memories, text history and totals
  kpm_datapath u_dp (
    .clk_i, .rst_ni, .ctl_i(ctl), .pattern_index_i, .char_pos_i, .data_byte_i,
    .pattern_length_i, .polarity_i, .stat_o(stat), .sentiment_o,
    .positive_count_o, .negative_count_o
  );

endmodule
